### src/segld_pkg.sv
// ----------------------------------------------------------------------------
// segld_pkg
// Types, codes and descriptor field constants for the segment register load.
// ----------------------------------------------------------------------------
`default_nettype none

package segld_pkg;

   // Number of segment registers
   localparam int SEG_COUNT = 6;

   // Segment register ids
   localparam logic [2:0] SEG_ES = 3'd0;
   localparam logic [2:0] SEG_CS = 3'd1;
   localparam logic [2:0] SEG_SS = 3'd2;

   // Fault codes
   localparam logic [1:0] FAULT_NONE = 2'd0;
   localparam logic [1:0] FAULT_GP   = 2'd1;
   localparam logic [1:0] FAULT_NP   = 2'd2;
   localparam logic [1:0] FAULT_INT  = 2'd3;

   // Load function codes
   localparam logic FUNC_CHECKED   = 1'b0;
   localparam logic FUNC_UNCHECKED = 1'b1;

   // Configuration register indexes
   localparam logic [1:0] CSR_GDT_BASE  = 2'd0;
   localparam logic [1:0] CSR_GDT_LIMIT = 2'd1;
   localparam logic [1:0] CSR_LDT_BASE  = 2'd2;
   localparam logic [1:0] CSR_LDT_LIMIT = 2'd3;

   // Access word bits
   localparam int ACC_P_BIT = 7;
   localparam int ACC_B_BIT = 14;
   localparam int ACC_G_BIT = 15;
   localparam logic [15:0] ACC_REAL_CLR = 16'h4060;   // B and DPL

   // Descriptor type groups (type is access bits 4..0)
   localparam logic [1:0] TYPE_DATA_HI   = 2'b10;     // 0x10..0x17
   localparam logic [3:0] TYPE_RD_CODE   = 4'b1101;   // 0x1A, 0x1B
   localparam logic [3:0] TYPE_CONF_CODE = 4'b1111;   // 0x1E, 0x1F

   localparam logic [15:0] REAL_LIMIT = 16'hFFFF;
   localparam logic [11:0] PAGE_FILL  = 12'hFFF;
   localparam logic [2:0]  BYTE_FIVE  = 3'd5;

   typedef struct packed {
      logic        func;
      logic [2:0]  seg_id;
      logic [15:0] selector;
      logic [31:0] desc_low;
      logic [31:0] desc_high;
      logic        protected_mode;
      logic        virtual_8086;
   } req_type;

   typedef struct packed {
      logic [1:0]  fault;
      logic [15:0] fault_code;
      logic [31:0] cache_base;
      logic [31:0] cache_limit;
      logic [15:0] cache_access;
      logic        access_write;
      logic [31:0] access_write_addr;
      logic [7:0]  access_write_byte;
      logic [1:0]  cpl_out;
      logic        code_32bit;
      logic        stack_32bit;
   } rsp_type;

   typedef struct packed {
      logic [31:0] gdt_base;
      logic [15:0] gdt_limit;
      logic [31:0] ldt_base;
      logic [31:0] ldt_limit;
   } cfg_type;

   // Machine state seen by and updated from one load
   typedef struct packed {
      logic        acc_we;
      logic [15:0] acc_val;
      logic [1:0]  cpl;
      logic        code_32bit;
      logic        stack_32bit;
   } upd_type;

endpackage

`default_nettype wire

### src/segld_csr.sv
// ----------------------------------------------------------------------------
// segld_csr
// Descriptor table base/limit registers behind an APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module segld_csr import segld_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready,
   output cfg_type          cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] idx;

   assign idx        = csr_paddr[3:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            CSR_GDT_BASE:  cfg_in.gdt_base  = csr_pwdata;
            CSR_GDT_LIMIT: cfg_in.gdt_limit = csr_pwdata[15:0];
            CSR_LDT_BASE:  cfg_in.ldt_base  = csr_pwdata;
            CSR_LDT_LIMIT: cfg_in.ldt_limit = csr_pwdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         CSR_GDT_BASE:  csr_prdata = cfg_ff.gdt_base;
         CSR_GDT_LIMIT: csr_prdata = {16'b0, cfg_ff.gdt_limit};
         CSR_LDT_BASE:  csr_prdata = cfg_ff.ldt_base;
         CSR_LDT_LIMIT: csr_prdata = cfg_ff.ldt_limit;
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gdt_base  <= '0;
         cfg_ff.gdt_limit <= 16'hFFFF;
         cfg_ff.ldt_base  <= '0;
         cfg_ff.ldt_limit <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

### src/segld_eval.sv
// ----------------------------------------------------------------------------
// segld_eval
// Single-pass check and decode of one segment load against current state.
// ----------------------------------------------------------------------------
`default_nettype none

module segld_eval import segld_pkg::*; #(
   parameter int NUM_SEGMENTS = SEG_COUNT
) (
   input  wire req_type      req,
   input  wire cfg_type      cfg,
   input  wire logic [15:0]  old_acc,    // cached access of the target
   input  wire logic [1:0]   cpl,
   input  wire logic         code_32bit,
   input  wire logic         stack_32bit,
   output rsp_type           rsp,
   output upd_type           upd
);

   logic        id_ok, is_cs, is_ss;
   logic        plain, prot, chk_ss, chk_data, null_sel;
   logic [31:0] lo, hi;
   logic [15:0] acc, sel_code;
   logic [4:0]  dtype;
   logic [1:0]  dpl, rpl;
   logic [31:0] tbl_lim, tbl_base, wb_addr;
   logic        in_tbl;
   logic [19:0] lim20;
   logic [31:0] dec_base, dec_lim;
   logic        ss_ok, data_ok, priv_ok;
   logic [1:0]  fault;
   logic [15:0] fcode;
   logic        install, good;

   assign id_ok = 32'(req.seg_id) < NUM_SEGMENTS;
   assign is_cs = req.seg_id == SEG_CS;
   assign is_ss = req.seg_id == SEG_SS;

   assign plain    = (req.func == FUNC_CHECKED) & (~req.protected_mode | req.virtual_8086);
   assign prot     = (req.func == FUNC_UNCHECKED) | (~plain & is_cs);
   assign chk_ss   = ~prot & ~plain & is_ss;
   assign chk_data = ~prot & ~plain & ~is_ss;

   assign sel_code = {req.selector[15:2], 2'b00};
   assign null_sel = sel_code == '0;

   // checked CS load uses an all-zero descriptor
   assign lo = (req.func == FUNC_CHECKED && is_cs) ? '0 : req.desc_low;
   assign hi = (req.func == FUNC_CHECKED && is_cs) ? '0 : req.desc_high;

   assign acc   = hi[23:8];
   assign dtype = acc[4:0];
   assign dpl   = acc[6:5];
   assign rpl   = req.selector[1:0];

   // table bounds and byte-five address
   assign tbl_lim  = req.selector[2] ? cfg.ldt_limit : {16'b0, cfg.gdt_limit};
   assign tbl_base = req.selector[2] ? cfg.ldt_base : cfg.gdt_base;
   assign in_tbl   = {16'b0, req.selector[15:3], 3'b111} <= tbl_lim;
   assign wb_addr  = tbl_base + {16'b0, req.selector[15:3], BYTE_FIVE};

   assign dec_base = {hi[31:24], hi[7:0], lo[31:16]};
   assign lim20    = {hi[19:16], lo[15:0]};
   assign dec_lim  = acc[ACC_G_BIT] ? {lim20, PAGE_FILL} : {12'b0, lim20};

   assign ss_ok = in_tbl && cpl == rpl && cpl == dpl
                  && dtype[4:3] == TYPE_DATA_HI && dtype[1] && acc[ACC_P_BIT];

   assign priv_ok = (dpl >= cpl) && (dpl >= rpl);
   always_comb begin
      if (dtype[4:3] == TYPE_DATA_HI || dtype[4:1] == TYPE_RD_CODE) begin
         data_ok = in_tbl & priv_ok;
      end else begin
         data_ok = in_tbl & (dtype[4:1] == TYPE_CONF_CODE);
      end
   end

   always_comb begin
      fault = FAULT_NONE;
      fcode = '0;
      if (!id_ok || plain) begin
         fault = FAULT_NONE;
      end else if (prot) begin
         if (!in_tbl) fault = FAULT_INT;
      end else if (chk_ss) begin
         if (null_sel) begin
            fault = FAULT_GP;
         end else if (!ss_ok) begin
            fault = FAULT_GP;
            fcode = sel_code;
         end
      end else if (!null_sel) begin
         if (!data_ok) begin
            fault = FAULT_GP;
            fcode = sel_code;
         end else if (!acc[ACC_P_BIT]) begin
            fault = FAULT_NP;
            fcode = sel_code;
         end
      end
   end

   assign good    = id_ok && fault == FAULT_NONE;
   assign install = good && (prot || chk_ss || (chk_data && !null_sel));

   always_comb begin
      rsp             = '0;
      rsp.fault       = fault;
      rsp.fault_code  = fcode;
      upd.acc_we      = good;
      upd.acc_val     = '0;
      upd.cpl         = cpl;
      upd.code_32bit  = code_32bit;
      upd.stack_32bit = stack_32bit;
      if (install) begin
         rsp.cache_base        = dec_base;
         rsp.cache_limit       = dec_lim;
         rsp.cache_access      = acc;
         rsp.access_write      = 1'b1;
         rsp.access_write_addr = wb_addr;
         rsp.access_write_byte = {hi[15:9], 1'b1};
         upd.acc_val           = acc;
         if (is_cs) begin
            upd.code_32bit = acc[ACC_B_BIT];
            upd.cpl        = rpl;
         end else if (is_ss) begin
            upd.stack_32bit = acc[ACC_B_BIT];
         end
      end else if (good && plain) begin
         rsp.cache_base   = {12'b0, req.selector, 4'b0};
         rsp.cache_limit  = {16'b0, REAL_LIMIT};
         rsp.cache_access = old_acc & ~ACC_REAL_CLR;
         upd.acc_val      = old_acc & ~ACC_REAL_CLR;
         if (is_cs) begin
            upd.code_32bit = 1'b0;
         end else if (is_ss) begin
            upd.stack_32bit = 1'b0;
         end
      end
      // null data selector: segment fields stay zero
      rsp.cpl_out     = upd.cpl;
      rsp.code_32bit  = upd.code_32bit;
      rsp.stack_32bit = upd.stack_32bit;
   end

endmodule

`default_nettype wire

### src/x86_segment_register_load.sv
// ----------------------------------------------------------------------------
// x86_segment_register_load
// Loads one x86 segment register, one load per cycle while rsp_stall does not
// hold the result. Each accepted word is captured in an input register,
// checked and decoded in a single pass, and the result word lands in a result
// register; rsp_valid rises once the load reaches that register. A new load is
// taken every cycle as long as the result register drains or is empty. The
// cached access words, CPL and the code/stack size flags are updated at the
// edge where a load moves from the input register to the result register, so
// the next load, when checked, already sees them. Throughput is set by that
// state update loop. The user must write table registers through the csr_ port
// only while no load is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module x86_segment_register_load import segld_pkg::*; #(
   parameter int NUM_SEGMENTS = SEG_COUNT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // load request
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   // load result
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   // table registers
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   localparam int IDX_W = $clog2(NUM_SEGMENTS);

   cfg_type     cfg;

   // input register
   logic        s1_valid_ff, s1_valid_in;
   req_type     s1_req_ff;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff;

   // machine state
   logic [15:0] acc_ff [NUM_SEGMENTS];
   logic [1:0]  cpl_ff;
   logic        code32_ff, stack32_ff;

   logic        advance, take;
   logic        id_ok;
   logic [IDX_W-1:0] idx;
   logic [15:0] old_acc;
   rsp_type     eval_rsp;
   upd_type     upd;

   segld_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // target register's cached access word (real-mode loads keep it with B and DPL cleared)
   assign idx     = s1_req_ff.seg_id[IDX_W-1:0];
   assign id_ok   = 32'(s1_req_ff.seg_id) < NUM_SEGMENTS;
   assign old_acc = id_ok ? acc_ff[idx] : '0;

   segld_eval #(
      .NUM_SEGMENTS (NUM_SEGMENTS)
   ) u_eval (
      .req         (s1_req_ff),
      .cfg         (cfg),
      .old_acc     (old_acc),
      .cpl         (cpl_ff),
      .code_32bit  (code32_ff),
      .stack_32bit (stack32_ff),
      .rsp         (eval_rsp),
      .upd         (upd)
   );

   // stage 1 moves on when the result register is free or draining
   assign advance      = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall    = s1_valid_ff & ~advance;
   assign take         = req_valid & ~req_stall;
   assign s1_valid_in  = take | (s1_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= eval_rsp;
      end
   end

   // state commit when the load retires into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         cpl_ff     <= '0;
         code32_ff  <= 1'b0;
         stack32_ff <= 1'b0;
         for (int i = 0; i < NUM_SEGMENTS; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (advance) begin
         cpl_ff     <= upd.cpl;
         code32_ff  <= upd.code_32bit;
         stack32_ff <= upd.stack_32bit;
         if (upd.acc_we && id_ok) begin
            acc_ff[idx] <= upd.acc_val;
         end
      end
   end

`ifndef SYNTHESIS
   // a faulting load never reports a write-back
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.fault != FAULT_NONE |-> !rsp_ff.access_write)
      else $error("write-back reported on a faulting load");

   // input side only stalls with a load held in stage 1
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("stall without a held load");

   // CPL only moves when a load retires
   assert property (@(posedge clock) disable iff (reset)
      cpl_ff != $past(cpl_ff) |-> $past(advance))
      else $error("CPL changed without a retiring load");

   // result register reflects the state committed with it
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_ff.cpl_out == cpl_ff && rsp_ff.code_32bit == code32_ff
                  && rsp_ff.stack_32bit == stack32_ff)
      else $error("result flags differ from committed state");
`endif

endmodule

`default_nettype wire
